// ===== rtl/core/wtc_pkg.sv =====
// Package for the word token classifier: sizes, token codes, keyword table,
// number scan phases and the result record.
// No dependencies.
package wtc_pkg;

  // Sizes
  localparam int LENGTH_BITS  = 16;
  localparam int OFFSET_BITS  = 32;
  localparam int PREFIX_CHARS = 7;
  localparam int PREFIX_W     = PREFIX_CHARS * 8;

  // Output queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // Signed 32-bit magnitude limit (valid only with a minus sign)
  localparam logic [35:0] NUM_LIMIT = 36'h0_8000_0000;

  // Special bytes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_VTAB    = 8'h0B;
  localparam logic [7:0] CH_FFEED   = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Token codes
  localparam logic [3:0] TOK_NONE    = 4'd0;
  localparam logic [3:0] TOK_VAR     = 4'd1;
  localparam logic [3:0] TOK_NEWLINE = 4'd2;
  localparam logic [3:0] TOK_ASSIGN  = 4'd3;
  localparam logic [3:0] TOK_NUMBER  = 4'd4;
  localparam logic [3:0] TOK_NAME    = 4'd5;
  localparam logic [3:0] TOK_PRINT   = 4'd6;
  localparam logic [3:0] TOK_PLUS    = 4'd7;
  localparam logic [3:0] TOK_MINUS   = 4'd8;
  localparam logic [3:0] TOK_MUL     = 4'd9;
  localparam logic [3:0] TOK_DIV     = 4'd10;
  localparam logic [3:0] TOK_LPAREN  = 4'd11;
  localparam logic [3:0] TOK_RPAREN  = 4'd12;

  // Keyword table: text with byte i at bits 8i, zero padded
  localparam int KW_COUNT = 12;
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0000_0072_6176,  // var
    64'h0065_6E69_4C77_654E,  // NewLine
    64'h0000_0000_0000_003D,  // =
    64'h0000_7265_626D_756E,  // number
    64'h0065_6D61_4E72_6176,  // varName
    64'h0000_0074_6E69_7270,  // print
    64'h0000_0000_0000_002B,  // +
    64'h0000_0000_0000_002D,  // -
    64'h0000_0000_0000_002A,  // *
    64'h0000_0000_0000_002F,  // /
    64'h0000_0000_0000_0028,  // (
    64'h0000_0000_0000_0029   // )
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd7, 4'd1, 4'd6, 4'd7, 4'd5, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
  };
  localparam logic [3:0] KW_TYPE [KW_COUNT] = '{
    TOK_VAR, TOK_NEWLINE, TOK_ASSIGN, TOK_NUMBER, TOK_NAME, TOK_PRINT,
    TOK_PLUS, TOK_MINUS, TOK_MUL, TOK_DIV, TOK_LPAREN, TOK_RPAREN
  };

  // Number scan phases
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE,
    PH_BAD
  } number_phase_t;

  // One result record
  typedef struct packed {
    logic [3:0]  token_type;
    logic [31:0] start_offset;
    logic [15:0] word_length;
    logic        last;
  } result_t;

  // Match a finished word against the keyword table; TOK_NONE if no hit.
  // Bytes past the word's length are zero, so a padded compare is exact.
  function automatic logic [3:0] kw_lookup(input logic [PREFIX_W-1:0]    prefix,
                                           input logic [LENGTH_BITS-1:0] len);
    logic [3:0] hit;
    hit = TOK_NONE;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (32'(len) == 32'(KW_LEN[k]) && 64'(prefix) == KW_TEXT[k]) begin
        hit = KW_TYPE[k];
      end
    end
    return hit;
  endfunction

endpackage

// ===== rtl/core/word_token_classifier_top.sv =====
// A delimiter's tokens are registered into the result queue when it is accepted and are offered on out_ in order.
// Throughput: one byte per cycle while in_ready is high; a newline after a word gives two tokens.
// A four-entry result queue separates the sides; in_ready drops when fewer than
// two slots are free. rst_n is synchronous, active low: it empties the queue,
// clears the word state and sets the stream position to zero.
// Depends on wtc_pkg.
module word_token_classifier_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_type,
  output logic [31:0] out_start_offset,
  output logic [15:0] out_word_length,
  output logic        out_last
);
  import wtc_pkg::*;

  // Word state
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [PREFIX_W-1:0]    prefix_r, prefix_nxt;
  number_phase_t          phase_r, phase_nxt;
  logic [31:0]            mag_r, mag_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   neg_r, neg_nxt;

  // Output queue
  result_t                q_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [OUTQ_CNT_W-1:0]  cnt_r;

  logic       acc, pop;
  logic       is_delim, is_nl, is_digit, is_ws, has_word;
  logic [3:0] digit;
  logic [35:0] mag_step;
  logic [3:0] kw_type, word_type;
  logic       is_number;
  result_t    res0, res1;
  logic       wr0, wr1;
  logic [63:0] start_wide, pos_wide;
  logic [31:0] len_wide;

  assign acc = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  // Decode the byte
  assign is_delim = (in_ch == CH_SPACE) || (in_ch == CH_NEWLINE);
  assign is_nl    = (in_ch == CH_NEWLINE);
  assign is_digit = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
  assign is_ws    = (in_ch == CH_TAB) || (in_ch == CH_VTAB) ||
                    (in_ch == CH_FFEED) || (in_ch == CH_CR);
  assign digit    = in_ch[3:0];
  assign has_word = (len_r != '0);

  // Next digit value: mag*10 + d, by shifts
  assign mag_step = (36'(mag_r) << 3) + (36'(mag_r) << 1) + 36'(digit);

  // Classify the pending word
  assign kw_type   = kw_lookup(prefix_r, len_r);
  assign is_number = ((phase_r == PH_DIGITS) || (phase_r == PH_DONE)) && !ovf_r &&
                     (!mag_r[31] || neg_r);
  always_comb begin
    priority if (kw_type != TOK_NONE) begin
      word_type = kw_type;
    end else if (is_number) begin
      word_type = TOK_NUMBER;
    end else begin
      word_type = TOK_NAME;
    end
  end

  // Build result records
  assign start_wide = 64'(start_r);
  assign pos_wide   = 64'(pos_r);
  assign len_wide   = 32'(len_r);
  always_comb begin
    res0 = '0;
    res1 = '0;
    wr0  = 1'b0;
    wr1  = 1'b0;
    if (acc && is_delim) begin
      if (has_word) begin
        res0.token_type   = word_type;
        res0.start_offset = start_wide[31:0];
        res0.word_length  = len_wide[15:0];
        res0.last         = !is_nl;
        wr0               = 1'b1;
        res1.token_type   = TOK_NEWLINE;
        res1.start_offset = pos_wide[31:0];
        res1.word_length  = '0;
        res1.last         = 1'b1;
        wr1               = is_nl;
      end else if (is_nl) begin
        res0.token_type   = TOK_NEWLINE;
        res0.start_offset = pos_wide[31:0];
        res0.word_length  = '0;
        res0.last         = 1'b1;
        wr0               = 1'b1;
      end
    end
  end

  // Advance word state
  always_comb begin
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    prefix_nxt = prefix_r;
    phase_nxt  = phase_r;
    mag_nxt    = mag_r;
    ovf_nxt    = ovf_r;
    neg_nxt    = neg_r;
    if (acc) begin
      pos_nxt = pos_r + 1'b1;
      if (is_delim) begin
        len_nxt    = '0;
        prefix_nxt = '0;
        phase_nxt  = PH_LEAD;
        mag_nxt    = '0;
        ovf_nxt    = 1'b0;
        neg_nxt    = 1'b0;
      end else begin
        if (!has_word) begin
          start_nxt = pos_r;
        end
        for (int i = 0; i < PREFIX_CHARS; i++) begin
          if (32'(len_r) == i) begin
            prefix_nxt[8*i +: 8] = in_ch;
          end
        end
        if (len_r != '1) begin
          len_nxt = len_r + 1'b1;
        end
        // Number scan
        unique case (phase_r)
          PH_LEAD: begin
            priority if (is_ws) begin
              phase_nxt = PH_LEAD;
            end else if (in_ch == CH_PLUS || in_ch == CH_MINUS) begin
              neg_nxt   = (in_ch == CH_MINUS);
              phase_nxt = PH_SIGN;
            end else if (is_digit) begin
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_BAD;
            end
          end
          PH_SIGN: begin
            phase_nxt = is_digit ? PH_DIGITS : PH_BAD;
          end
          PH_DIGITS: begin
            if (!is_digit) begin
              phase_nxt = PH_DONE;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
        // Accumulate a digit that extends the leading run
        if (is_digit && !ovf_r &&
            (phase_r == PH_LEAD || phase_r == PH_SIGN || phase_r == PH_DIGITS)) begin
          if (mag_step > NUM_LIMIT) begin
            ovf_nxt = 1'b1;
          end else begin
            mag_nxt = mag_step[31:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      start_r  <= '0;
      len_r    <= '0;
      prefix_r <= '0;
      phase_r  <= PH_LEAD;
      mag_r    <= '0;
      ovf_r    <= 1'b0;
      neg_r    <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      prefix_r <= prefix_nxt;
      phase_r  <= phase_nxt;
      mag_r    <= mag_nxt;
      ovf_r    <= ovf_nxt;
      neg_r    <= neg_nxt;
    end
  end

  // Queue storage: write up to two records per request
  always_ff @(posedge clk) begin
    if (wr0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (wr1) begin
      q_r[wr_ptr_r + 1'b1] <= res1;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OUTQ_PTR_W'(wr0) + OUTQ_PTR_W'(wr1);
      rd_ptr_r <= rd_ptr_r + OUTQ_PTR_W'(pop);
      cnt_r    <= cnt_r + OUTQ_CNT_W'(wr0) + OUTQ_CNT_W'(wr1) - OUTQ_CNT_W'(pop);
    end
  end

  // Hold off input until two slots are free
  assign in_ready  = (cnt_r <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
  assign out_valid = (cnt_r != '0);

  assign out_token_type   = q_r[rd_ptr_r].token_type;
  assign out_start_offset = q_r[rd_ptr_r].start_offset;
  assign out_word_length  = q_r[rd_ptr_r].word_length;
  assign out_last         = q_r[rd_ptr_r].last;

endmodule

// ===== rtl/core/wtc_checker.sv =====
// Port-level checks for word_token_classifier_top, attached by bind.
// Depends on wtc_pkg.
module wtc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_token_type,
  input logic [31:0] out_start_offset,
  input logic [15:0] out_word_length,
  input logic        out_last
);
  import wtc_pkg::*;

  // Come out of reset with the result side empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Hold a stalled result request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_type) &&
    $stable(out_start_offset) && $stable(out_word_length) && $stable(out_last))
    else $error("stalled result changed");

  // Token codes stay in the defined range
  a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_token_type != TOK_NONE) && (out_token_type <= TOK_RPAREN))
    else $error("token code out of range");

  // An empty length marks only the closing newline token
  a_empty_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word_length == '0) |-> (out_token_type == TOK_NEWLINE) && out_last)
    else $error("zero-length token that is not a closing newline");

endmodule

bind word_token_classifier_top wtc_checker u_wtc_checker (.*);

// ===== dv/tb_word_token_classifier_top.sv =====
// Self-checking testbench for word_token_classifier_top: feeds byte streams
// under random request gaps and result stalls, and predicts every token.
// Depends on wtc_pkg and the word_token_classifier_top RTL.
module tb_word_token_classifier_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wtc_pkg::*;

  localparam int CYCLE_LIMIT  = 600_000;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_LIMIT = 100;
  localparam int LONG_WORD    = 120;

  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_mode_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_ch     = 8'h00;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [3:0]  out_token_type;
  logic [31:0] out_start_offset;
  logic [15:0] out_word_length;
  logic        out_last;

  word_token_classifier_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ch            (in_ch),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_type   (out_token_type),
    .out_start_offset (out_start_offset),
    .out_word_length  (out_word_length),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Token predictor state
  logic [OFFSET_BITS-1:0] stream_pos = '0;
  logic [OFFSET_BITS-1:0] word_start = '0;
  logic [LENGTH_BITS-1:0] cur_len    = '0;
  logic [PREFIX_W-1:0]    word_text  = '0;  // first bytes, newest at the low end
  number_phase_t          scan_phase = PH_LEAD;
  logic [35:0]            magnitude  = '0;
  logic                   too_big    = 1'b0;
  logic                   negative   = 1'b0;

  result_t    tokens_due[$];
  idle_mode_t in_mode  = IDLE_FULL;
  idle_mode_t out_mode = IDLE_FULL;
  int         out_hold = 0;
  int         err_count = 0;
  int         bytes_sent = 0;
  int         tokens_seen = 0;
  int         kind_seen[16];

  function automatic int draw_wait(input idle_mode_t m);
    case (m)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
      default:   return $urandom_range(0, 12);
    endcase
  endfunction

  // Keyword first, then number, else name
  function automatic logic [3:0] word_kind();
    logic [3:0] kind;
    kind = TOK_NONE;
    case (cur_len)
      1: begin
        case (word_text[7:0])
          "=":     kind = TOK_ASSIGN;
          "+":     kind = TOK_PLUS;
          "-":     kind = TOK_MINUS;
          "*":     kind = TOK_MUL;
          "/":     kind = TOK_DIV;
          "(":     kind = TOK_LPAREN;
          ")":     kind = TOK_RPAREN;
          default: kind = TOK_NONE;
        endcase
      end
      3: if (word_text[23:0] == "var") kind = TOK_VAR;
      5: if (word_text[39:0] == "print") kind = TOK_PRINT;
      6: if (word_text[47:0] == "number") kind = TOK_NUMBER;
      7: begin
        if (word_text == "NewLine") kind = TOK_NEWLINE;
        else if (word_text == "varName") kind = TOK_NAME;
      end
      default: kind = TOK_NONE;
    endcase
    if (kind == TOK_NONE) begin
      if ((scan_phase == PH_DIGITS || scan_phase == PH_DONE) && !too_big &&
          (magnitude < NUM_LIMIT || negative))
        kind = TOK_NUMBER;
      else
        kind = TOK_NAME;
    end
    return kind;
  endfunction

  // Accumulate one digit; stick at overflow once past the signed limit
  task automatic add_digit(input logic [7:0] c);
    logic [35:0] nxt;
    nxt = magnitude * 36'd10 + 36'(c - CH_ZERO);
    if (!too_big) begin
      if (nxt > NUM_LIMIT) too_big = 1'b1;
      else magnitude = nxt;
    end
  endtask

  task automatic scan_number(input logic [7:0] c);
    logic is_digit;
    is_digit = (c >= CH_ZERO && c <= CH_NINE);
    case (scan_phase)
      PH_LEAD: begin
        if (c == CH_TAB || c == CH_VTAB || c == CH_FFEED || c == CH_CR) begin
          scan_phase = PH_LEAD;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          negative   = (c == CH_MINUS);
          scan_phase = PH_SIGN;
        end else if (is_digit) begin
          add_digit(c);
          scan_phase = PH_DIGITS;
        end else begin
          scan_phase = PH_BAD;
        end
      end
      PH_SIGN: begin
        if (is_digit) begin
          add_digit(c);
          scan_phase = PH_DIGITS;
        end else begin
          scan_phase = PH_BAD;
        end
      end
      PH_DIGITS: begin
        if (is_digit) add_digit(c);
        else scan_phase = PH_DONE;
      end
      default: scan_phase = scan_phase;
    endcase
  endtask

  // Predict the tokens caused by one accepted byte
  task automatic tokenize_byte(input logic [7:0] c);
    result_t tok;
    logic [OFFSET_BITS-1:0] here;
    here = stream_pos;
    stream_pos = stream_pos + 1'b1;
    if (c == CH_SPACE || c == CH_NEWLINE) begin
      if (cur_len != 0) begin
        tok.token_type   = word_kind();
        tok.start_offset = word_start[31:0];
        tok.word_length  = 16'(cur_len);
        tok.last         = (c != CH_NEWLINE);
        tokens_due.insert(tokens_due.size(), tok);
      end
      if (c == CH_NEWLINE) begin
        tok.token_type   = TOK_NEWLINE;
        tok.start_offset = here[31:0];
        tok.word_length  = '0;
        tok.last         = 1'b1;
        tokens_due.insert(tokens_due.size(), tok);
      end
      cur_len    = '0;
      word_text  = '0;
      scan_phase = PH_LEAD;
      magnitude  = '0;
      too_big    = 1'b0;
      negative   = 1'b0;
    end else begin
      if (cur_len == 0) word_start = here;
      if (cur_len < PREFIX_CHARS) word_text = {word_text[PREFIX_W-9:0], c};
      if (cur_len != '1) cur_len = cur_len + 1'b1;
      scan_number(c);
    end
  endtask

  // Offer one byte after a random gap, hold it until the request is taken
  task automatic send_byte(input logic [7:0] ch);
    int gap;
    gap = draw_wait(in_mode);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tokenize_byte(ch);
    bytes_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string keyword_text(input int k);
    case (k)
      0:       return "var";
      1:       return "NewLine";
      2:       return "=";
      3:       return "number";
      4:       return "varName";
      5:       return "print";
      6:       return "+";
      7:       return "-";
      8:       return "*";
      9:       return "/";
      10:      return "(";
      default: return ")";
    endcase
  endfunction

  function automatic string near_keyword(input int k);
    case (k)
      0:       return "va";
      1:       return "vars";
      2:       return "Print";
      3:       return "NewLin";
      4:       return "newline";
      5:       return "NewLinex";
      6:       return "varNam";
      7:       return "numbers";
      8:       return "==";
      9:       return "()";
      default: return "variable";
    endcase
  endfunction

  // Random number word: leading blanks, sign, zeros, value, trailing junk
  task automatic send_number();
    longint unsigned v;
    string junk;
    junk = ".x+-e";
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 3))
          0:       send_byte(CH_TAB);
          1:       send_byte(CH_VTAB);
          2:       send_byte(CH_FFEED);
          default: send_byte(CH_CR);
        endcase
      end
    end
    case ($urandom_range(0, 2))
      0:       send_byte(CH_PLUS);
      1:       send_byte(CH_MINUS);
      default: ;
    endcase
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_byte(CH_ZERO);
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 9);
      1: v = $urandom_range(0, 99999);
      2: begin
        case ($urandom_range(0, 4))
          0:       v = 64'd2147483647;
          1:       v = 64'd2147483648;
          2:       v = 64'd2147483649;
          3:       v = 64'd4294967295;
          default: v = 64'd0;
        endcase
      end
      3: v = $urandom;
      4: v = {$urandom, $urandom};
      default: v = $urandom_range(0, 999);
    endcase
    send_str($sformatf("%0d", v));
    if ($urandom_range(0, 3) == 0) begin
      send_byte(junk[$urandom_range(0, 4)]);
      if ($urandom_range(0, 1) == 0) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    end
  endtask

  task automatic send_name();
    int n;
    logic [7:0] b;
    n = $urandom_range(1, 9);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        b = $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                 : 8'("A" + $urandom_range(0, 25));
      end else begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_SPACE || b == CH_NEWLINE) b = "_";
      end
      send_byte(b);
    end
  endtask

  task automatic send_broken();
    case ($urandom_range(0, 5))
      0:       send_str("+-1");
      1:       send_str("\t");
      2:       send_str("\r-");
      3:       send_str("-x9");
      4:       send_str("+");
      default: send_str("\t\t+");
    endcase
  endtask

  task automatic send_delimiter();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) send_byte(CH_SPACE);
    else if (r < 18) send_byte(CH_NEWLINE);
    else begin
      send_byte($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE);
      send_byte($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE);
    end
  endtask

  // Empty words, signed extremes, blank and sign prefix, NUL and high bytes
  task automatic test_edge_words();
    in_mode  = IDLE_FULL;
    out_mode = IDLE_FULL;
    send_str(" \n");
    send_str("-2147483648 ");
    send_str("\t+007x\n");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_SPACE);
  endtask

  // Stream one word far past the keyword prefix, no idling
  task automatic test_long_word();
    logic [7:0] b;
    in_mode  = IDLE_NONE;
    out_mode = IDLE_NONE;
    send_str("123");
    repeat (LONG_WORD - 3) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_SPACE || b == CH_NEWLINE) b = "a";
      send_byte(b);
    end
    send_byte(CH_NEWLINE);
  endtask

  // Mostly well-formed statements and words with random content, some noise
  task automatic test_random_stream(input int n_bytes);
    int first;
    int units;
    int r;
    first = bytes_sent;
    units = 0;
    while (bytes_sent - first < n_bytes) begin
      if (units % 30 == 0) begin
        in_mode  = idle_mode_t'($urandom_range(0, 2));
        out_mode = idle_mode_t'($urandom_range(0, 2));
      end
      units++;
      r = $urandom_range(0, 19);
      if (r < 5) begin
        send_str(keyword_text($urandom_range(0, 11)));
      end else if (r < 9) begin
        send_number();
      end else if (r < 12) begin
        send_name();
      end else if (r < 14) begin
        send_str(near_keyword($urandom_range(0, 10)));
      end else if (r == 14) begin
        send_broken();
      end else if (r == 15) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (r < 18) begin
        send_str("var ");
        send_name();
        send_str(" = ");
        send_number();
        send_byte(CH_NEWLINE);
      end else begin
        send_str("print ( ");
        send_name();
        send_str($urandom_range(0, 1) ? " + " : " * ");
        send_number();
        send_str(" )");
      end
      send_delimiter();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Compare each taken result with the oldest predicted token
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_LIMIT)
          $display("%0t: unexpected token: expected none, actual type %0d offset %0d len %0d",
                   $time, out_token_type, out_start_offset, out_word_length);
      end else begin
        want = tokens_due.pop_front();
        check_field("token_type", 32'(want.token_type), 32'(out_token_type));
        check_field("start_offset", want.start_offset, out_start_offset);
        check_field("word_length", 32'(want.word_length), 32'(out_word_length));
        check_field("last", 32'(want.last), 32'(out_last));
        tokens_seen++;
        kind_seen[want.token_type]++;
      end
      out_hold = draw_wait(out_mode);
    end
  end

  // Hold out_ready low while out_hold, drawn after each taken result, counts down
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold = out_hold - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // End the run if it hangs
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles, %0d tokens still due", $time, cycles,
             tokens_due.size());
    $display("** word_token_classifier_top: FAILED **");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edge_words();
    test_long_word();
    test_random_stream(760);

    // Drop the request line and let every predicted token come out
    @(negedge clk);
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes, including a %0d-byte word; checked %0d tokens.",
             bytes_sent, LONG_WORD, tokens_seen);
    $display("Token mix: %0d numbers, %0d names, %0d newlines, %0d other keywords; %0d errors.",
             kind_seen[TOK_NUMBER], kind_seen[TOK_NAME], kind_seen[TOK_NEWLINE],
             tokens_seen - kind_seen[TOK_NUMBER] - kind_seen[TOK_NAME]
             - kind_seen[TOK_NEWLINE], err_count);
    if (err_count == 0) begin
      $display("** word_token_classifier_top: PASSED **");
    end else begin
      $display("** word_token_classifier_top: FAILED **");
    end
    $finish;
  end

endmodule
